/* rtl/core/sdfd_pkg.sv */
// shared types, constants and coefficient table for the downmix decimator
package sdfd_pkg;

	localparam int TAP_COUNT_DEF = 15;
	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 16;
	localparam int PROD_W        = SAMPLE_W + COEF_W;
	localparam int ACC_W         = 32;
	localparam int FRAC_BITS     = 15;
	localparam int RATE_W        = 16;
	localparam int PHASE_W       = 17;
	localparam int COEF_IDX_W    = 4;

	localparam logic [PHASE_W-1:0] PHASE_WRAP = PHASE_W'(48000);
	localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(16000);

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] sample;
	} mac_res_t;

	function automatic logic signed [COEF_W-1:0] tap_coef(input logic [COEF_IDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		unique case (idx)
			4'd0, 4'd14: c = 16'sd110;
			4'd1, 4'd13: c = 16'sd154;
			4'd2, 4'd12: c = -16'sd201;
			4'd3, 4'd11: c = -16'sd1136;
			4'd4, 4'd10: c = -16'sd851;
			4'd5, 4'd9:  c = 16'sd3035;
			4'd6, 4'd8:  c = 16'sd9157;
			4'd7:        c = 16'sd12232;
			default:     c = '0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/sdfd_hist_mem.sv */
// sample history memory, one write and one registered read port, cleared entries read as zero
module sdfd_hist_mem
	import sdfd_pkg::*;
#(
	parameter int DEPTH = TAP_COUNT_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic signed [SAMPLE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic signed [SAMPLE_W-1:0] rd_data
);

	logic signed [SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]           valid_q;
	logic signed [SAMPLE_W-1:0] rd_data_q;
	logic                       rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/core/sdfd_mac.sv */
// shared multiply-accumulate unit with final shift and saturation
module sdfd_mac
	import sdfd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  mac_ctl_t                   ctl_s1,
	input  logic signed [SAMPLE_W-1:0] sample_s1,
	input  logic signed [COEF_W-1:0]   coef_s1,
	output mac_res_t                   res
);

	mac_ctl_t                   ctl_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       done_q;
	logic signed [ACC_W-FRAC_BITS-1:0] shifted;

	always_ff @(posedge clk) begin
		prod_s2 <= sample_s1 * coef_s1;
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	assign shifted = acc_q[ACC_W-1:FRAC_BITS];

	always_comb begin
		res.valid = done_q;
		priority if (shifted > (ACC_W-FRAC_BITS)'(SAT_MAX)) begin
			res.sample = SAT_MAX;
		end else if (shifted < (ACC_W-FRAC_BITS)'(SAT_MIN)) begin
			res.sample = SAT_MIN;
		end else begin
			res.sample = shifted[SAMPLE_W-1:0];
		end
	end

endmodule

/* rtl/core/stereo_downmix_fir_decimator_unit.sv */
// top level: downmix, history write, rate phase and filter sequencer
//
// Each stereo frame is downmixed to mono and written into a 15-entry history
// memory in the cycle it is accepted. A frame that yields no output sample
// leaves the input open. A frame that yields one keeps the input closed
// while the sequencer walks the history memory one read per cycle through
// a single shared multiplier and accumulator, and a further wait is added if
// the previous output sample is still held in the output register. Output
// samples leave from a register, so the next frame can be taken while one
// waits. The history reads as zero after reset without any clearing pass.
module stereo_downmix_fir_decimator_unit
	import sdfd_pkg::*;
#(
	parameter int TAP_COUNT = TAP_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [RATE_W-1:0] cfg_wr_data,   // output_rate
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [63:0]       s_axis_tdata,  // left_slot, right_slot
	input  logic              s_axis_tlast,  // last_frame
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // out_sample
	output logic              m_axis_tlast   // ends_block
);

	localparam int AW = $clog2(TAP_COUNT);
	localparam logic [AW-1:0] LAST_IDX = AW'(TAP_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT_OUT,
		ST_RUN,
		ST_FLUSH
	} state_t;

	state_t               state_q;
	logic [RATE_W-1:0]    rate_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [AW-1:0]        wp_q;
	logic [AW-1:0]        cur_q;
	logic [AW-1:0]        tap_q;
	logic                 last_q;

	logic                 in_acc;
	logic [PHASE_W-1:0]   phase_sum;
	logic                 emit;
	logic [SAMPLE_W:0]    mix_sum;
	logic [SAMPLE_W:0]    mix_adj;
	logic signed [SAMPLE_W-1:0] mono;
	logic                 out_free;

	mac_ctl_t                   ctl_s0;
	mac_ctl_t                   ctl_s1;
	logic signed [COEF_W-1:0]   coef_s1;
	logic signed [SAMPLE_W-1:0] rd_data;
	mac_res_t                   mac_res;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// truncating average of the two upper halves
	assign mix_sum = {s_axis_tdata[31], s_axis_tdata[31:16]}
	               + {s_axis_tdata[63], s_axis_tdata[63:48]};
	assign mix_adj = mix_sum + {{SAMPLE_W{1'b0}}, mix_sum[SAMPLE_W]};
	assign mono    = mix_adj[SAMPLE_W:1];

	assign phase_sum = phase_q + {{(PHASE_W-RATE_W){1'b0}}, rate_q};
	assign emit      = (phase_sum >= PHASE_WRAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_wr_en) begin
			rate_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= '0;
			wp_q          <= '0;
			cur_q         <= '0;
			tap_q         <= '0;
			last_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wp_q   <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
						cur_q  <= wp_q;
						tap_q  <= '0;
						last_q <= s_axis_tlast;
						if (emit) begin
							phase_q <= phase_sum - PHASE_WRAP;
							state_q <= out_free ? ST_RUN : ST_WAIT_OUT;
						end else begin
							phase_q <= phase_sum;
						end
					end
				end
				ST_WAIT_OUT: begin
					if (out_free) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cur_q <= (cur_q == '0) ? LAST_IDX : cur_q - 1'b1;
					tap_q <= tap_q + 1'b1;
					if (tap_q == LAST_IDX) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (mac_res.valid) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= mac_res.sample;
						m_axis_tlast  <= last_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl_s0.valid = (state_q == ST_RUN);
		ctl_s0.first = (tap_q == '0);
		ctl_s0.last  = (tap_q == LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= tap_coef(COEF_IDX_W'(tap_q));
	end

	sdfd_hist_mem #(
		.DEPTH(TAP_COUNT)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (in_acc),
		.wr_addr(wp_q),
		.wr_data(mono),
		.rd_en  (ctl_s0.valid),
		.rd_addr(cur_q),
		.rd_data(rd_data)
	);

	sdfd_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.sample_s1(rd_data),
		.coef_s1  (coef_s1),
		.res      (mac_res)
	);

endmodule

/* rtl/core/sdfd_checker.sv */
// port-level checks on the decimator top level, bound in below
module sdfd_checker
	import sdfd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [15:0]       m_axis_tdata,
	input logic              m_axis_tlast
);

	// stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// input closes only after taking an item
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid))
		else $error("input closed without an accepted item");

	// a new result comes only from a filter run with the input closed
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready) && !$past(s_axis_tready, 2))
		else $error("result appeared without a filter run");

	// input reopens only after the filter run hands over its result
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) && !$past(s_axis_tready, 2) |-> m_axis_tvalid)
		else $error("input reopened without a result");

endmodule

bind stereo_downmix_fir_decimator_unit sdfd_checker u_sdfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

/* test/stereo_downmix_fir_decimator_unit_test.sv */
// self-checking testbench for the stereo downmix fir decimator with a sample-level predictor
module stereo_downmix_fir_decimator_unit_test;
	import sdfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 40;
	localparam int TAP_WEIGHTS [TAP_COUNT_DEF] = '{
		110, 154, -201, -1136, -851, 3035, 9157, 12232,
		9157, 3035, -851, -1136, -201, 154, 110
	};

	typedef enum int {
		PAT_NOISE,
		PAT_QUIET,
		PAT_SIGNED_RUN,
		PAT_HELD_EXTREME
	} frame_pattern_t;

	typedef struct {
		logic [31:0] left;
		logic [31:0] right;
		logic        last;
	} stereo_frame_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       ends_block;
	} mono_sample_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_wr_en     = 1'b0;
	logic [RATE_W-1:0] cfg_wr_data   = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [63:0]       s_axis_tdata  = '0;  // left_slot, right_slot
	logic              s_axis_tlast  = 1'b0; // last_frame
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [15:0]       m_axis_tdata;         // out_sample
	logic              m_axis_tlast;         // ends_block

	// predictor state
	logic signed [SAMPLE_W-1:0] history [TAP_COUNT_DEF] = '{default: '0};
	int                         write_pos   = 0;
	logic [PHASE_W-1:0]         rate_phase  = '0;
	logic [RATE_W-1:0]          output_rate = RATE_RESET;

	stereo_frame_t frame_q [$];
	mono_sample_t  pending_samples [$];
	stereo_frame_t next_frame;

	logic in_fire    = 1'b0;
	logic out_fire   = 1'b0;
	logic src_gaps   = 1'b0;
	logic sink_gaps  = 1'b0;
	int   src_wait   = 0;
	int   sink_wait  = 0;
	int   fail_count = 0;
	int   cycle_count = 0;

	stereo_downmix_fir_decimator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void downmix_and_filter(input logic [31:0] left_slot,
			input logic [31:0] right_slot, input logic last);
		logic signed [SAMPLE_W-1:0] left_top;
		logic signed [SAMPLE_W-1:0] right_top;
		int                         mono;
		longint                     acc;
		int                         cursor;
		mono_sample_t               res;
		left_top  = left_slot[31:16];
		right_top = right_slot[31:16];
		// average truncates toward zero
		mono = (int'(left_top) + int'(right_top)) / 2;
		history[write_pos] = SAMPLE_W'(mono);
		write_pos = (write_pos == TAP_COUNT_DEF - 1) ? 0 : write_pos + 1;
		rate_phase = PHASE_W'(rate_phase + PHASE_W'(output_rate));
		if (rate_phase >= PHASE_WRAP) begin
			rate_phase = rate_phase - PHASE_WRAP;
			acc = 0;
			cursor = write_pos;
			for (int t = 0; t < TAP_COUNT_DEF; t++) begin
				cursor = (cursor == 0) ? TAP_COUNT_DEF - 1 : cursor - 1;
				acc += longint'(history[cursor]) * longint'(TAP_WEIGHTS[t]);
			end
			acc = acc >>> FRAC_BITS;
			if (acc > longint'(SAT_MAX))
				res.sample = SAT_MAX;
			else if (acc < longint'(SAT_MIN))
				res.sample = SAT_MIN;
			else
				res.sample = SAMPLE_W'(acc);
			res.ends_block = last;
			pending_samples.push_back(res);
		end
	endfunction

	// handshake sampling, prediction and checking
	always @(posedge clk) begin
		mono_sample_t want;
		in_fire  <= arst_n && s_axis_tvalid && s_axis_tready;
		out_fire <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_samples.size() == 0) begin
					$error("unexpected output item: out_sample %0d, ends_block %0b",
						$signed(m_axis_tdata), m_axis_tlast);
					fail_count++;
				end else begin
					want = pending_samples.pop_front();
					if (m_axis_tdata !== want.sample) begin
						$error("out_sample mismatch: expected %0d, actual %0d",
							want.sample, $signed(m_axis_tdata));
						fail_count++;
					end
					if (m_axis_tlast !== want.ends_block) begin
						$error("ends_block mismatch: expected %0b, actual %0b",
							want.ends_block, m_axis_tlast);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				downmix_and_filter(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
		end
	end

	// frame driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (in_fire || !s_axis_tvalid) begin
			if (src_wait > 0) begin
				src_wait--;
				s_axis_tvalid <= 1'b0;
			end else if (frame_q.size() != 0) begin
				next_frame = frame_q.pop_front();
				s_axis_tdata  <= {next_frame.right, next_frame.left};
				s_axis_tlast  <= next_frame.last;
				s_axis_tvalid <= 1'b1;
				src_wait = src_gaps ? $urandom_range(0, 9) : 0;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output sink with random back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (out_fire)
				sink_wait = sink_gaps ? $urandom_range(0, 9) : 0;
			if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_frame(input logic [31:0] left, input logic [31:0] right,
			input logic last);
		stereo_frame_t f;
		f.left  = left;
		f.right = right;
		f.last  = last;
		frame_q.push_back(f);
	endtask

	task automatic queue_random_frames(input int count);
		frame_pattern_t pat;
		int             run;
		int             k;
		logic           polarity;
		logic [15:0]    left_top;
		logic [15:0]    right_top;
		stereo_frame_t  f;
		k = 0;
		while (k < count) begin
			pat = frame_pattern_t'($urandom_range(0, 3));
			run = (pat == PAT_SIGNED_RUN) ? TAP_COUNT_DEF : $urandom_range(1, 20);
			polarity = $urandom_range(0, 1);
			for (int j = 0; j < run && k < count; j++) begin
				case (pat)
					PAT_QUIET: begin
						left_top  = 16'($urandom_range(0, 1023)) - 16'd512;
						right_top = 16'($urandom_range(0, 1023)) - 16'd512;
					end
					PAT_SIGNED_RUN: begin
						// signs follow the taps so the sum pushes into saturation
						left_top  = ((TAP_WEIGHTS[j] > 0) ^ polarity) ? 16'h7fff : 16'h8000;
						right_top = left_top;
					end
					PAT_HELD_EXTREME: begin
						left_top  = polarity ? 16'h8000 : 16'h7fff;
						right_top = $urandom_range(0, 3) == 0 ? 16'($urandom) : left_top;
					end
					default: begin
						left_top  = 16'($urandom);
						right_top = 16'($urandom);
					end
				endcase
				f.left  = {left_top, 16'($urandom)};
				f.right = {right_top, 16'($urandom)};
				f.last  = ($urandom_range(0, 7) == 0);
				frame_q.push_back(f);
				k++;
			end
		end
	endtask

	task automatic wait_idle();
		while (frame_q.size() != 0 || s_axis_tvalid || pending_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_output_rate(input logic [RATE_W-1:0] rate);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rate;
		output_rate = rate;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [RATE_W-1:0] phase_rates [11];
		int                n_frames;
		phase_rates = '{16'd65535, 16'd0, 16'd1, 16'd47999, 16'd24000, 16'd16000,
			RATE_W'($urandom_range(1, 48000)), RATE_W'($urandom_range(1, 48000)),
			RATE_W'($urandom_range(48001, 65535)), 16'd12000, 16'd48000};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// one output per frame so every directed frame is seen
		set_output_rate(16'd48000);
		push_frame(32'h7fffffff, 32'h7fffffff, 1'b0);
		push_frame(32'h80000000, 32'h80000000, 1'b1);
		push_frame(32'h7fffffff, 32'h80000000, 1'b0);
		push_frame(32'h80000000, 32'h7fffffff, 1'b1);
		push_frame(32'h00000000, 32'h00000000, 1'b0);
		push_frame(32'hffffffff, 32'hffffffff, 1'b1);
		push_frame(32'hffff0000, 32'h00000000, 1'b0);
		push_frame(32'h0000ffff, 32'h0000ffff, 1'b1);
		push_frame(32'hfffd0000, 32'h00000000, 1'b0);
		// full-scale run matching the tap signs drives the output into saturation
		for (int j = 0; j < TAP_COUNT_DEF; j++)
			push_frame(TAP_WEIGHTS[j] > 0 ? 32'h7fffffff : 32'h80000000,
				TAP_WEIGHTS[j] > 0 ? 32'h7fffffff : 32'h80000000, j[0]);
		wait_idle();

		foreach (phase_rates[p]) begin
			src_gaps  = (p % 4 != 1) && ($urandom_range(0, 3) != 0);
			sink_gaps = (p % 4 != 1) && ($urandom_range(0, 3) != 0);
			set_output_rate(phase_rates[p]);
			n_frames = (phase_rates[p] <= 16'd1) ? 30 : 120;
			queue_random_frames(n_frames);
			wait_idle();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
rtl/core/sdfd_pkg.sv
rtl/core/sdfd_hist_mem.sv
rtl/core/sdfd_mac.sv
rtl/core/stereo_downmix_fir_decimator_unit.sv
rtl/core/sdfd_checker.sv
test/stereo_downmix_fir_decimator_unit_test.sv
